[src/tklk_pkg.sv]
// Shared types, sizes and codes for the top-k label keeper.
package tklk_pkg;

  // Storage sizes
  localparam int unsigned Slots     = 4;
  localparam int unsigned LabelBits = 10;
  localparam int unsigned SlotW     = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CntW      = $clog2(Slots + 1);

  // Fixed field widths
  localparam int unsigned ProbW     = 14;
  localparam int unsigned LabelInW  = 10;
  localparam int unsigned ActionW   = 2;
  localparam int unsigned SlotOutW  = 2;
  localparam int unsigned CountOutW = 3;
  localparam int unsigned MaxKeptW  = 3;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned DataW     = 32;

  localparam logic [ProbW-1:0] FullScale = ProbW'(10000);

  typedef enum logic [ActionW-1:0] {
    ACT_BELOW   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_DROP    = 2'd3
  } action_e;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_MAX_KEPT  = 1'b1
  } reg_idx_e;

  // Running minimum handed along the cell chain
  typedef struct packed {
    logic             found;
    logic [ProbW-1:0] conf;
    logic [SlotW-1:0] pos;
  } search_t;

  // Slot write command from the sequencer to one cell
  typedef struct packed {
    logic                 en;
    logic [LabelBits-1:0] label;
    logic [ProbW-1:0]     conf;
  } slot_wr_t;

endpackage

[src/tklk_cfg.sv]
// APB-style configuration registers: threshold and max_kept.
module tklk_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tklk_pkg::AddrW-1:0]    paddr,
  input  logic [tklk_pkg::DataW-1:0]    pwdata,
  output logic [tklk_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output logic [tklk_pkg::ProbW-1:0]    threshold_o,
  output logic [tklk_pkg::MaxKeptW-1:0] max_kept_o
);

  logic [tklk_pkg::ProbW-1:0]    threshold_q;
  logic [tklk_pkg::MaxKeptW-1:0] max_kept_q;
  tklk_pkg::reg_idx_e            reg_sel;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_sel = tklk_pkg::reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      max_kept_q  <= tklk_pkg::MaxKeptW'(4);
    end else if (wr_en) begin
      unique case (reg_sel)
        tklk_pkg::REG_THRESHOLD: threshold_q <= pwdata[tklk_pkg::ProbW-1:0];
        tklk_pkg::REG_MAX_KEPT:  max_kept_q  <= pwdata[tklk_pkg::MaxKeptW-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_sel)
      tklk_pkg::REG_THRESHOLD: prdata = tklk_pkg::DataW'(threshold_q);
      tklk_pkg::REG_MAX_KEPT:  prdata = tklk_pkg::DataW'(max_kept_q);
      default:                 prdata = '0;
    endcase
  end

  assign threshold_o = threshold_q;
  assign max_kept_o  = max_kept_q;

endmodule

[src/tklk_cell.sv]
// One kept slot: holds a label and its confidence, folds itself into the running minimum.
module tklk_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [tklk_pkg::SlotW-1:0]     cell_idx_i,
  input  logic                           active_i,
  input  tklk_pkg::slot_wr_t             wr_i,
  input  tklk_pkg::search_t              search_i,
  output tklk_pkg::search_t              search_o,
  output logic [tklk_pkg::LabelBits-1:0] label_o
);

  logic [tklk_pkg::LabelBits-1:0] label_q;
  logic [tklk_pkg::ProbW-1:0]     conf_q;
  tklk_pkg::search_t              search_d, search_q;
  logic                           take;

  // Store a new label and confidence
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      label_q <= wr_i.label;
      conf_q  <= wr_i.conf;
    end
  end

  // Take over the minimum on strictly lower confidence, so ties stay with the lower slot
  always_comb begin
    take     = active_i && (!search_i.found || (conf_q < search_i.conf));
    search_d = search_i;
    if (take) begin
      search_d.found = 1'b1;
      search_d.conf  = conf_q;
      search_d.pos   = cell_idx_i;
    end
  end

  // Hand the minimum to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_q <= '0;
    end else begin
      search_q <= search_d;
    end
  end

  assign search_o = search_q;
  assign label_o  = label_q;

endmodule

[src/top_k_label_keeper_core.sv]
// Top level of the top-k label keeper: sequencer, cell chain and result register.
//
// Keeps up to Slots (4) labels per box in a chain of slot cells. Per accepted
// label the running minimum walks the chain one cell per cycle, then the decide
// state writes the slot and loads the result register, waiting while a held
// result is stalled. The block works on one label at a time; in_stall_o is
// high while a label is in flight, and a finished result waiting on out_stall_i
// does not block taking the next label. start_box clears the kept count before
// its own label is handled. Probabilities above 10000 are saturated first.
// Registers: threshold at byte address 0, max_kept at byte address 4 (0 acts
// as 1, values above the slot count act as the slot count).
module top_k_label_keeper_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tklk_pkg::AddrW-1:0]     paddr,
  input  logic [tklk_pkg::DataW-1:0]     pwdata,
  output logic [tklk_pkg::DataW-1:0]     prdata,
  output logic                           pready,
  // label input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           start_box_i,
  input  logic [tklk_pkg::LabelInW-1:0]  label_index_i,
  input  logic [tklk_pkg::ProbW-1:0]     probability_i,
  input  logic                           last_label_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tklk_pkg::ActionW-1:0]   action_o,
  output logic [tklk_pkg::SlotOutW-1:0]  slot_o,
  output logic [tklk_pkg::LabelInW-1:0]  evicted_label_o,
  output logic [tklk_pkg::CountOutW-1:0] kept_count_o,
  output logic                           box_done_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DECIDE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [tklk_pkg::ProbW-1:0]    threshold;
  logic [tklk_pkg::MaxKeptW-1:0] max_kept;

  // Held item
  logic                           item_start_q;
  logic [tklk_pkg::LabelBits-1:0] item_label_q;
  logic [tklk_pkg::ProbW-1:0]     item_prob_q;
  logic                           item_last_q;
  logic [tklk_pkg::ProbW-1:0]     prob_sat;

  logic [tklk_pkg::CntW-1:0]  total_q, total_d, total_eff, limit;
  logic [tklk_pkg::SlotW-1:0] step_q, step_d;

  // Result register
  logic                           out_valid_q;
  tklk_pkg::action_e              action_q, action_d;
  logic [tklk_pkg::SlotW-1:0]     slot_q, slot_d;
  logic [tklk_pkg::LabelBits-1:0] evicted_q, evicted_d;
  logic [tklk_pkg::CntW-1:0]      count_q;
  logic                           done_q;

  logic                           accept, decide;
  tklk_pkg::search_t              chain [tklk_pkg::Slots+1];
  tklk_pkg::slot_wr_t             wr    [tklk_pkg::Slots];
  logic [tklk_pkg::Slots-1:0]     active;
  logic [tklk_pkg::LabelBits-1:0] cell_label [tklk_pkg::Slots];
  tklk_pkg::search_t              min_res;
  logic                           wr_en;
  logic [tklk_pkg::SlotW-1:0]     wr_slot;

  tklk_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .threshold_o (threshold),
    .max_kept_o  (max_kept)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign decide     = (state_q == ST_DECIDE) && (!out_valid_q || !out_stall_i);

  // Saturate the probability at full scale
  assign prob_sat = (probability_i > tklk_pkg::FullScale) ? tklk_pkg::FullScale
                                                          : probability_i;

  // Latch the accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_start_q <= start_box_i;
      item_label_q <= tklk_pkg::LabelBits'(label_index_i);
      item_prob_q  <= prob_sat;
      item_last_q  <= last_label_i;
    end
  end

  // Clamp max_kept into one to Slots
  always_comb begin
    if (max_kept == '0) begin
      limit = tklk_pkg::CntW'(1);
    end else if (32'(max_kept) > tklk_pkg::Slots) begin
      limit = tklk_pkg::CntW'(tklk_pkg::Slots);
    end else begin
      limit = tklk_pkg::CntW'(max_kept);
    end
  end

  assign total_eff = item_start_q ? '0 : total_q;

  // Cell chain: the running minimum enters empty at the head
  assign chain[0] = '0;

  for (genvar j = 0; j < tklk_pkg::Slots; j++) begin : g_cell
    assign active[j] = (tklk_pkg::CntW'(j) < total_eff);
    assign wr[j].en    = wr_en && (wr_slot == tklk_pkg::SlotW'(j));
    assign wr[j].label = item_label_q;
    assign wr[j].conf  = item_prob_q;

    tklk_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (tklk_pkg::SlotW'(j)),
      .active_i   (active[j]),
      .wr_i       (wr[j]),
      .search_i   (chain[j]),
      .search_o   (chain[j+1]),
      .label_o    (cell_label[j])
    );
  end

  assign min_res = chain[tklk_pkg::Slots];

  // Decide: append, replace the minimum, drop, or ignore
  always_comb begin
    action_d  = tklk_pkg::ACT_BELOW;
    slot_d    = '0;
    evicted_d = '0;
    total_d   = total_eff;
    wr_en     = 1'b0;
    wr_slot   = '0;
    if (item_prob_q >= threshold) begin
      if (total_eff >= limit) begin
        if (item_prob_q > min_res.conf) begin
          action_d  = tklk_pkg::ACT_REPLACE;
          slot_d    = min_res.pos;
          evicted_d = cell_label[min_res.pos];
          wr_en     = decide;
          wr_slot   = min_res.pos;
        end else begin
          action_d = tklk_pkg::ACT_DROP;
        end
      end else begin
        action_d = tklk_pkg::ACT_APPEND;
        slot_d   = tklk_pkg::SlotW'(total_eff);
        total_d  = total_eff + tklk_pkg::CntW'(1);
        wr_en    = decide;
        wr_slot  = tklk_pkg::SlotW'(total_eff);
      end
    end
  end

  // Sequence: search the chain, then decide
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SEARCH;
          step_d  = '0;
        end
      end
      ST_SEARCH: begin
        step_d = step_q + tklk_pkg::SlotW'(1);
        if (step_q == tklk_pkg::SlotW'(tklk_pkg::Slots - 1)) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (decide) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (decide) begin
        total_q <= total_d;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (decide) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (decide) begin
      action_q  <= action_d;
      slot_q    <= slot_d;
      evicted_q <= evicted_d;
      count_q   <= total_d;
      done_q    <= item_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign action_o        = action_q;
  assign slot_o          = tklk_pkg::SlotOutW'(slot_q);
  assign evicted_label_o = tklk_pkg::LabelInW'(evicted_q);
  assign kept_count_o    = tklk_pkg::CountOutW'(count_q);
  assign box_done_o      = done_q;

endmodule
